// File: rtl/stb_pkg.sv
// Shared types and constants for the soft timer bank.
// No dependencies; used by stb_mod_unit and soft_timer_bank_unit.
package stb_pkg;

  localparam int CNT_W     = 32;
  localparam int STEP_BITS = 2;
  localparam int DIV_STEPS = CNT_W / STEP_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int ACT_W    = 3;
  localparam int SLOTF_W  = 2;
  localparam int PERF_W   = 16;
  localparam int IN_DW    = 24;
  localparam int MASK_W   = 4;
  localparam int OUT_DW   = 8;
  localparam int SLOTCMP_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 3'd0,
    ACT_ALLOC = 3'd1,
    ACT_FREE  = 3'd2,
    ACT_SET   = 3'd3,
    ACT_START = 3'd4,
    ACT_STOP  = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

endpackage

// File: rtl/stb_mod_unit.sv
// Iterative remainder unit: 32-bit dividend modulo a PERIOD_BITS divisor,
// two restoring steps per cycle. Depends on stb_pkg.
module stb_mod_unit #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [stb_pkg::CNT_W-1:0]      dividend,
  input  logic [PERIOD_BITS-1:0]         divisor,
  output logic                           done,
  output logic [PERIOD_BITS-1:0]         remainder
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [stb_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [stb_pkg::CNT_W-1:0]    div_r, div_nxt;
  logic [PERIOD_BITS-1:0]       rem_r, rem_nxt;
  logic [PERIOD_BITS-1:0]       dsr_r, dsr_nxt;
  logic [PERIOD_BITS-1:0]       rem_step;
  logic [stb_pkg::CNT_W-1:0]    div_step;

  always_comb begin
    logic [PERIOD_BITS:0] t;
    logic [PERIOD_BITS-1:0] r;
    logic [stb_pkg::CNT_W-1:0] d;
    r = rem_r;
    d = div_r;
    for (int k = 0; k < stb_pkg::STEP_BITS; k++) begin
      t = {r, d[stb_pkg::CNT_W-1]};
      d = {d[stb_pkg::CNT_W-2:0], 1'b0};
      if (t >= {1'b0, dsr_r}) begin
        t = t - {1'b0, dsr_r};
      end
      r = t[PERIOD_BITS-1:0];
    end
    rem_step = r;
    div_step = d;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      div_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      div_nxt = div_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + stb_pkg::STEP_W'(1);
      if (cnt_r == stb_pkg::STEP_W'(stb_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: rtl/soft_timer_bank_unit.sv
// Top level of the soft timer bank: slot state, command decode, tick sequencer.
// Depends on stb_pkg and stb_mod_unit.
//
// A bank of SLOTS soft timers on a free-running 32-bit tick count. A tick item
// runs the start and wait states once per slot: the single remainder unit
// resolves two bits of count modulo period per cycle and is reused for every
// slot in turn. Allocate, free, set, start and stop items go straight from idle
// to the output state. One item is in flight at a time; in_tready is low until
// its result has been taken on the output. Only slots 0 to 3 show in fire_mask.
module soft_timer_bank_unit #(
  parameter int SLOTS       = 4,
  parameter int PERIOD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] action, [4:3] slot, [20:5] period, [21] repeat_req, [23:22] zero
  input  logic [stb_pkg::IN_DW-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [3:0] fire_mask, [4] status, [6:5] new_slot, [7] zero
  output logic [stb_pkg::OUT_DW-1:0]    out_tdata
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FIRE_W = (SLOTS > stb_pkg::MASK_W) ? SLOTS : stb_pkg::MASK_W;

  stb_pkg::state_t state_r, state_nxt;

  logic [stb_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [SLOTS-1:0]              used_r, used_nxt;
  logic [SLOTS-1:0]              run_r, run_nxt;
  logic [SLOTS-1:0]              fired_r, fired_nxt;
  logic [SLOTS-1:0]              rpt_r, rpt_nxt;
  logic [PERIOD_BITS-1:0]        period_r [SLOTS];
  logic [PERIOD_BITS-1:0]        period_nxt [SLOTS];
  logic [SLOT_W-1:0]             idx_r, idx_nxt;
  logic [FIRE_W-1:0]             fire_r, fire_nxt;
  logic                          status_r, status_nxt;
  logic [stb_pkg::SLOTF_W-1:0]   grant_r, grant_nxt;
  logic                          ovalid_r, ovalid_nxt;

  logic [stb_pkg::ACT_W-1:0]     in_action;
  logic [stb_pkg::SLOTF_W-1:0]   in_slot;
  logic [stb_pkg::PERF_W-1:0]    in_period;
  logic                          in_repeat;
  logic [SLOT_W-1:0]             sidx;
  logic                          in_range;
  logic                          free_found;
  logic [SLOT_W-1:0]             free_idx;
  logic                          mod_start;
  logic                          mod_done;
  logic [PERIOD_BITS-1:0]        mod_rem;
  logic                          accept;

  assign in_action = in_tdata[2:0];
  assign in_slot   = in_tdata[4:3];
  assign in_period = in_tdata[20:5];
  assign in_repeat = in_tdata[21];
  assign sidx      = SLOT_W'(in_slot);
  assign in_range  = stb_pkg::SLOTCMP_W'(in_slot) < stb_pkg::SLOTCMP_W'(SLOTS);
  assign in_tready = (state_r == stb_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign mod_start = (state_r == stb_pkg::ST_START);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!free_found && !used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  stb_mod_unit #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (count_r),
    .divisor  (period_r[idx_r]),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    used_nxt   = used_r;
    run_nxt    = run_r;
    fired_nxt  = fired_r;
    rpt_nxt    = rpt_r;
    period_nxt = period_r;
    idx_nxt    = idx_r;
    fire_nxt   = fire_r;
    status_nxt = status_r;
    grant_nxt  = grant_r;
    ovalid_nxt = ovalid_r;
    case (state_r)
      stb_pkg::ST_IDLE: begin
        if (accept) begin
          fire_nxt   = '0;
          status_nxt = 1'b0;
          grant_nxt  = '0;
          case (in_action)
            stb_pkg::ACT_TICK: begin
              count_nxt = count_r + stb_pkg::CNT_W'(1);
              idx_nxt   = '0;
              state_nxt = stb_pkg::ST_START;
            end
            stb_pkg::ACT_ALLOC: begin
              if (free_found) begin
                used_nxt[free_idx]  = 1'b1;
                run_nxt[free_idx]   = 1'b0;
                fired_nxt[free_idx] = 1'b0;
                grant_nxt           = stb_pkg::SLOTF_W'(free_idx);
              end else begin
                status_nxt = 1'b1;
              end
            end
            stb_pkg::ACT_FREE: begin
              if (in_range) used_nxt[sidx] = 1'b0;
              else status_nxt = 1'b1;
            end
            stb_pkg::ACT_SET: begin
              if (in_range && used_r[sidx]) begin
                period_nxt[sidx] = PERIOD_BITS'(in_period);
                rpt_nxt[sidx]    = in_repeat;
              end else begin
                status_nxt = 1'b1;
              end
            end
            stb_pkg::ACT_START: begin
              if (in_range) run_nxt[sidx] = 1'b1;
              else status_nxt = 1'b1;
            end
            stb_pkg::ACT_STOP: begin
              if (in_range) run_nxt[sidx] = 1'b0;
              else status_nxt = 1'b1;
            end
            default: begin
              status_nxt = 1'b1;
            end
          endcase
          if (in_action != stb_pkg::ACT_TICK) begin
            ovalid_nxt = 1'b1;
            state_nxt  = stb_pkg::ST_OUT;
          end
        end
      end
      stb_pkg::ST_START: begin
        state_nxt = stb_pkg::ST_WAIT;
      end
      stb_pkg::ST_WAIT: begin
        if (mod_done) begin
          if (used_r[idx_r] && run_r[idx_r] && (period_r[idx_r] != '0) &&
              (mod_rem == '0) && (rpt_r[idx_r] || !fired_r[idx_r])) begin
            fired_nxt[idx_r] = 1'b1;
            fire_nxt[idx_r]  = 1'b1;
          end
          if (idx_r == SLOT_W'(SLOTS - 1)) begin
            ovalid_nxt = 1'b1;
            state_nxt  = stb_pkg::ST_OUT;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            state_nxt = stb_pkg::ST_START;
          end
        end
      end
      stb_pkg::ST_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        ovalid_nxt = 1'b0;
        state_nxt  = stb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= stb_pkg::ST_IDLE;
      count_r  <= '0;
      used_r   <= '0;
      run_r    <= '0;
      fired_r  <= '0;
      rpt_r    <= '0;
      ovalid_r <= 1'b0;
      idx_r    <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        period_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      used_r   <= used_nxt;
      run_r    <= run_nxt;
      fired_r  <= fired_nxt;
      rpt_r    <= rpt_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
      period_r <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fire_r   <= fire_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, grant_r, status_r, fire_r[stb_pkg::MASK_W-1:0]};

endmodule
